### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (reset active low).
`define PCPG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that stays on during reset.
`define PCPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/pcpg_pkg.sv
// Types, constants and helpers for the punk console pulse generator.
package pcpg_pkg;

  // Phase and period formats
  localparam int unsigned PHASE_W   = 25;
  localparam int unsigned PERIOD_W  = 24;
  localparam int unsigned VOL_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PHASE_W-1:0]  PHASE_MAX   = {PHASE_W{1'b1}};
  localparam logic [PERIOD_W-1:0] TRIG_RESET  = 24'd614400;
  localparam logic [PERIOD_W-1:0] PULSE_RESET = 24'd307200;
  localparam logic [PHASE_W-1:0]  NEXT_RESET  = 25'd614400;
  localparam logic [VOL_W-1:0]    VOL_MAX     = 7'd100;

  // Defaults for the top-level parameters
  localparam int unsigned PHASE_FRAC_BITS_DEF = 8;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_PERIOD = 2'd0,
    REG_PULSE_LENGTH   = 2'd1,
    REG_VOLUME         = 2'd2
  } cfg_reg_e;

  // Waveform segment reported with each sample
  typedef enum logic [1:0] {
    WP_LOW  = 2'd0,
    WP_RISE = 2'd1,
    WP_HIGH = 2'd2,
    WP_FALL = 2'd3
  } wave_phase_e;

  // Add two phase values, saturating at the top of the phase range
  function automatic logic [PHASE_W-1:0] sat_add(input logic [PHASE_W-1:0] a,
                                                 input logic [PHASE_W-1:0] b);
    logic [PHASE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PHASE_W] ? PHASE_MAX : s[PHASE_W-1:0];
  endfunction

endpackage

### rtl/pcpg_if.sv
// Stream channels of the pulse generator: tick input and sample output.
interface pcpg_in_if;
  logic valid;
  logic ready;
  logic enable;

  modport source (output valid, output enable, input ready);
  modport sink   (input valid, input enable, output ready);
endinterface

interface pcpg_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  import pcpg_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  wave_phase_e                   wave_phase;

  modport source (output valid, output sample, output wave_phase, input ready);
  modport sink   (input valid, input sample, input wave_phase, output ready);
endinterface

### rtl/pcpg_vol_scale.sv
// Volume scaler: level times volume, then exact divide by 100 via reciprocal.
module pcpg_vol_scale import pcpg_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [SAMPLE_BITS-1:0] level_i,
  input  logic [VOL_W-1:0]              vol_i,
  input  wave_phase_e                   wp_i,
  pcpg_out_if.source                    out_ch_o
);

  // Product width, shift and reciprocal; exact floor(x/100) for x below 2^PROD_W
  localparam int unsigned PROD_W  = SAMPLE_BITS + VOL_W;
  localparam int unsigned SHIFT   = PROD_W + 7;
  localparam int unsigned RECIP_W = PROD_W + 1;
  localparam int unsigned FULL_W  = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'd99) / 64'd100);

  logic                   s2_v_q;
  logic [PROD_W-1:0]      prod_q;
  logic                   neg_q;
  wave_phase_e            s2_wp_q;
  logic                   o_v_q;
  logic [SAMPLE_BITS-1:0] o_sample_q;
  wave_phase_e            o_wp_q;

  logic                   rdy2;
  logic                   rdy3;
  logic [SAMPLE_BITS-1:0] mag;
  logic [FULL_W-1:0]      quot_full;
  logic [SAMPLE_BITS-1:0] quot;
  logic [SAMPLE_BITS-1:0] sample_d;

  // Advance a stage when it is empty or the one after it moves
  assign rdy3    = !o_v_q || out_ch_o.ready;
  assign rdy2    = !s2_v_q || rdy3;
  assign ready_o = rdy2;

  // Magnitude of the level; the most negative value maps to its unsigned pattern
  assign mag = level_i[SAMPLE_BITS-1] ? (~level_i + 1'b1) : level_i;

  // Divide the registered product by 100 and restore the sign
  assign quot_full = FULL_W'(prod_q) * FULL_W'(RECIP);
  assign quot      = SAMPLE_BITS'(quot_full >> SHIFT);
  assign sample_d  = neg_q ? (~quot + 1'b1) : quot;

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (rdy2) begin
        s2_v_q <= valid_i;
      end
      if (rdy3) begin
        o_v_q <= s2_v_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy2 && valid_i) begin
      prod_q  <= PROD_W'(mag) * PROD_W'(vol_i);
      neg_q   <= level_i[SAMPLE_BITS-1];
      s2_wp_q <= wp_i;
    end
    if (rdy3 && s2_v_q) begin
      o_sample_q <= sample_d;
      o_wp_q     <= s2_wp_q;
    end
  end

  assign out_ch_o.valid      = o_v_q;
  assign out_ch_o.sample     = o_sample_q;
  assign out_ch_o.wave_phase = o_wp_q;

endmodule

### rtl/punk_console_pulse_generator_core.sv
// Top level of the punk console pulse generator: phase state, level update, output pipe.
//
//   channel   | direction | carries              | handshake
//   ----------+-----------+----------------------+-------------------
//   in_ch_i   | sink      | enable               | valid / ready
//   out_ch_o  | source    | sample, wave_phase   | valid / ready
//   cfg_*_i   | write     | idx, data            | we, no wait
//
// One word is taken per cycle unless the output stalls; results go to the first stage.
// The phase and level update finishes in the accept cycle.
// The volume product and the reciprocal divide by 100 each take one pipeline stage.
// Stalls on the output back up stage by stage; a stage that is empty still takes a word.
// Reset presets the registers and oscillator state and clears the pipe's valid flags.
module punk_console_pulse_generator_core import pcpg_pkg::*; #(
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [PERIOD_W-1:0]   cfg_data_i,
  pcpg_in_if.sink               in_ch_i,
  pcpg_out_if.source            out_ch_o
);

  localparam logic [PHASE_W-1:0] ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
  localparam logic [SAMPLE_BITS-1:0] LEVEL_LOW  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] LEVEL_HIGH = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam int unsigned RAMP_W = PHASE_FRAC_BITS + SAMPLE_BITS;

  // Scale a sub-sample phase difference to the full level span
  function automatic logic [SAMPLE_BITS-1:0] ramp(input logic [PHASE_W-1:0] d);
    logic [RAMP_W-1:0] w;
    w = RAMP_W'(d[PHASE_FRAC_BITS-1:0]) << SAMPLE_BITS;
    return SAMPLE_BITS'(w >> PHASE_FRAC_BITS);
  endfunction

  logic [PERIOD_W-1:0]    trig_q;
  logic [PERIOD_W-1:0]    pulse_q;
  logic [VOL_W-1:0]       vol_q;
  logic [PHASE_W-1:0]     pa_q,  pa_d;
  logic [PHASE_W-1:0]     nt_q,  nt_d;
  logic [SAMPLE_BITS-1:0] lvl_q, lvl_d;
  wave_phase_e            wp_d;

  logic                   s1_v_q;
  logic [SAMPLE_BITS-1:0] s1_lvl_q;
  logic [VOL_W-1:0]       s1_vol_q;
  wave_phase_e            s1_wp_q;

  logic                   s1_rdy;
  logic                   sc_rdy;
  logic                   accept;
  logic [PHASE_W-1:0]     tp_c;
  logic [PHASE_W-1:0]     pl_c;
  logic [VOL_W-1:0]       vol_c;
  logic [PHASE_W-1:0]     pa_inc;
  logic [PHASE_W-1:0]     d_rise;
  logic [PHASE_W-1:0]     d_fall;

  // Handshake
  assign s1_rdy        = !s1_v_q || sc_rdy;
  assign in_ch_i.ready = s1_rdy;
  assign accept        = in_ch_i.valid && s1_rdy;

  // Clamp periods to one sample and volume to 100 percent
  assign tp_c  = ({1'b0, trig_q} < ONE)  ? ONE : {1'b0, trig_q};
  assign pl_c  = ({1'b0, pulse_q} < ONE) ? ONE : {1'b0, pulse_q};
  assign vol_c = (vol_q > VOL_MAX) ? VOL_MAX : vol_q;

  assign pa_inc = sat_add(pa_q, ONE);
  assign d_rise = pa_q - nt_q;
  assign d_fall = pa_q - pl_c;

  // Next oscillator state for an enabled tick
  always_comb begin
    pa_d  = pa_inc;
    nt_d  = nt_q;
    lvl_d = lvl_q;
    wp_d  = WP_LOW;
    if (pa_q >= nt_q) begin
      wp_d = WP_RISE;
      if (d_rise >= ONE) begin
        lvl_d = LEVEL_HIGH;
        pa_d  = sat_add(d_rise, ONE);
        nt_d  = tp_c;
      end else begin
        lvl_d = LEVEL_LOW + ramp(d_rise);
      end
    end else if (lvl_q != LEVEL_LOW && pa_q >= pl_c) begin
      wp_d = WP_FALL;
      if (d_fall >= ONE) begin
        lvl_d = LEVEL_LOW;
      end else begin
        lvl_d = LEVEL_HIGH - ramp(d_fall);
      end
    end else if (lvl_q != LEVEL_LOW) begin
      wp_d = WP_HIGH;
      // absorb trigger points passed while high
      if (pa_inc >= nt_q) begin
        nt_d = sat_add(nt_q, tp_c);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q  <= TRIG_RESET;
      pulse_q <= PULSE_RESET;
      vol_q   <= VOL_MAX;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TRIGGER_PERIOD: trig_q  <= cfg_data_i;
        REG_PULSE_LENGTH:   pulse_q <= cfg_data_i;
        REG_VOLUME:         vol_q   <= cfg_data_i[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Oscillator state; hold it on disabled ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q  <= '0;
      nt_q  <= NEXT_RESET;
      lvl_q <= LEVEL_LOW;
    end else if (accept && in_ch_i.enable) begin
      pa_q  <= pa_d;
      nt_q  <= nt_d;
      lvl_q <= lvl_d;
    end
  end

  // First pipe stage: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_ch_i.valid;
    end
  end

  // First pipe stage: new level, segment and gain; silence when disabled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_lvl_q <= in_ch_i.enable ? lvl_d : '0;
      s1_wp_q  <= in_ch_i.enable ? wp_d : WP_LOW;
      s1_vol_q <= vol_c;
    end
  end

  pcpg_vol_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_vol_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_v_q),
    .ready_o  (sc_rdy),
    .level_i  (s1_lvl_q),
    .vol_i    (s1_vol_q),
    .wp_i     (s1_wp_q),
    .out_ch_o (out_ch_o)
  );

endmodule

### rtl/pcpg_checker.sv
// Port-level checks for the pulse generator core, bound to the top level.
`include "assert_macros.svh"

module pcpg_checker import pcpg_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample,
  input logic [1:0]             wave_phase
);

  localparam logic [1:0] PH_LOW = WP_LOW;

  // A stalled word keeps its sample
  `PCPG_ASSERT(a_hold_sample, clk_i, rst_ni, out_valid && !out_ready |=> $stable(sample), "sample changed while stalled")

  // A stalled word is not withdrawn
  `PCPG_ASSERT(a_hold_valid, clk_i, rst_ni, out_valid && !out_ready |=> out_valid, "output valid dropped while stalled")

  // An empty output register never blocks the input
  `PCPG_ASSERT(a_in_ready, clk_i, rst_ni, !out_valid |-> in_ready, "input stalled with empty output")

  // The low segment and silence never give a positive sample
  `PCPG_ASSERT(a_low_sign, clk_i, rst_ni, out_valid && wave_phase == PH_LOW |-> sample[SAMPLE_BITS-1] || sample == '0, "positive sample in low segment")

  // Nothing is offered right after reset
  `PCPG_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid, "output valid after reset")

endmodule

bind punk_console_pulse_generator_core pcpg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_pcpg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_ch_i.ready),
  .out_valid  (out_ch_o.valid),
  .out_ready  (out_ch_o.ready),
  .sample     (out_ch_o.sample),
  .wave_phase (out_ch_o.wave_phase)
);

### sim/punk_console_pulse_generator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the punk console pulse generator core.
module punk_console_pulse_generator_core_tb;
  import pcpg_pkg::*;

  localparam int unsigned CLK_HALF        = 4;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned DRAIN_PAD       = 8;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned RAND_TICKS      = 64;
  localparam int unsigned SOAK_TICKS      = 64;
  localparam int unsigned CYCLE_LIMIT     = 1500000;
  localparam int unsigned SAMPLE_W        = SAMPLE_BITS_DEF;

  localparam logic [PHASE_W-1:0]   ONE_SMP      = PHASE_W'(1) << PHASE_FRAC_BITS_DEF;
  localparam logic [PERIOD_W-1:0]  ONE_PER      = PERIOD_W'(1) << PHASE_FRAC_BITS_DEF;
  localparam logic [PERIOD_W-1:0]  SUB_SAMPLE   = PERIOD_W'(ONE_PER - 1);
  localparam logic [PERIOD_W-1:0]  PERIOD_ALL   = {PERIOD_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int                   LVL_LOW      = -(1 << (SAMPLE_W - 1));
  localparam int                   LVL_HIGH     = (1 << (SAMPLE_W - 1)) - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    wave_phase_e                wave_phase;
  } sample_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PERIOD_W-1:0]  cfg_data_i;

  pcpg_in_if                            in_ch ();
  pcpg_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

  punk_console_pulse_generator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  // Pending tick words and expected sample words
  bit           tick_q[$];
  sample_word_t sample_exp_q[$];

  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  bit          hold_on       = 1'b0;
  int unsigned hold_cnt      = 0;
  int unsigned err_cnt       = 0;
  int unsigned cyc_cnt       = 0;

  // Oscillator shadow: registers and state as the block should hold them
  logic [PERIOD_W-1:0] trig_period;
  logic [PERIOD_W-1:0] pulse_len;
  logic [VOL_W-1:0]    vol_pct;
  logic [PHASE_W-1:0]  ph_acc;
  logic [PHASE_W-1:0]  nxt_trig;
  int                  lvl;
  wave_phase_e         last_wp;

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic logic [PHASE_W-1:0] phase_add_sat(input logic [PHASE_W-1:0] a,
                                                       input logic [PHASE_W-1:0] b);
    logic [PHASE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, PHASE_MAX}) ? PHASE_MAX : s[PHASE_W-1:0];
  endfunction

  // Advance the oscillator by one tick and queue the sample word it yields
  task automatic step_oscillator(input logic en);
    logic [PHASE_W-1:0] tp;
    logic [PHASE_W-1:0] pl;
    logic [PHASE_W-1:0] d;
    int unsigned        vol;
    int                 scaled;
    sample_word_t       w;
    tp  = (trig_period < ONE_SMP) ? ONE_SMP : PHASE_W'(trig_period);
    pl  = (pulse_len < ONE_SMP) ? ONE_SMP : PHASE_W'(pulse_len);
    vol = 32'((vol_pct > VOL_MAX) ? VOL_MAX : vol_pct);
    if (!en) begin
      // silence, state untouched
      w.sample     = '0;
      w.wave_phase = WP_LOW;
    end else begin
      if (ph_acc >= nxt_trig) begin
        d       = ph_acc - nxt_trig;
        last_wp = WP_RISE;
        if (d >= ONE_SMP) begin
          lvl      = LVL_HIGH;
          ph_acc   = phase_add_sat(d, ONE_SMP);
          nxt_trig = tp;
        end else begin
          lvl    = LVL_LOW + (int'(d) << (SAMPLE_W - PHASE_FRAC_BITS_DEF));
          ph_acc = phase_add_sat(ph_acc, ONE_SMP);
        end
      end else if (lvl > LVL_LOW && ph_acc >= pl) begin
        d       = ph_acc - pl;
        last_wp = WP_FALL;
        lvl     = (d >= ONE_SMP) ? LVL_LOW
                                 : LVL_HIGH - (int'(d) << (SAMPLE_W - PHASE_FRAC_BITS_DEF));
        ph_acc  = phase_add_sat(ph_acc, ONE_SMP);
      end else if (lvl > LVL_LOW) begin
        // hold high and skip any trigger passed inside the pulse
        last_wp = WP_HIGH;
        ph_acc  = phase_add_sat(ph_acc, ONE_SMP);
        if (ph_acc >= nxt_trig) begin
          nxt_trig = phase_add_sat(nxt_trig, tp);
        end
      end else begin
        last_wp = WP_LOW;
        ph_acc  = phase_add_sat(ph_acc, ONE_SMP);
      end
      scaled       = (lvl * int'(vol)) / 100;
      w.sample     = SAMPLE_W'(scaled);
      w.wave_phase = last_wp;
    end
    sample_exp_q.push_back(w);
  endtask

  // Compare one sample word against the oldest expectation
  task automatic check_word();
    sample_word_t w;
    if (sample_exp_q.size() == 0) begin
      err_cnt++;
      $display("%0t: sample word with nothing expected, got sample %0d wave_phase %0d",
               $time, out_ch.sample, out_ch.wave_phase);
    end else begin
      w = sample_exp_q.pop_front();
      if (out_ch.sample !== w.sample) begin
        err_cnt++;
        $display("%0t: sample mismatch, expected %0d, got %0d", $time, w.sample, out_ch.sample);
      end
      if (out_ch.wave_phase !== w.wave_phase) begin
        err_cnt++;
        $display("%0t: wave_phase mismatch, expected %0d, got %0d",
                 $time, w.wave_phase, out_ch.wave_phase);
      end
    end
  endtask

  // Driver: predict each accepted tick, then offer the next pending word
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      in_ch.enable <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        step_oscillator(in_ch.enable);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_ch.valid  <= 1'b1;
          in_ch.enable <= tick_q.pop_front();
        end else begin
          in_ch.valid  <= 1'b0;
          in_ch.enable <= 1'($urandom_range(1));
        end
      end
    end
  end

  // Monitor: check accepted sample words, drive ready with stalls and hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_word();
      end
      if (hold_on && hold_cnt < HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
        hold_cnt     <= hold_cnt + 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        if (!hold_on) begin
          hold_cnt <= 0;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TRIGGER_PERIOD: trig_period = data;
      REG_PULSE_LENGTH:   pulse_len   = data;
      REG_VOLUME:         vol_pct     = data[VOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [PERIOD_W-1:0] tp, input logic [PERIOD_W-1:0] pl,
                            input logic [PERIOD_W-1:0] vol);
    write_reg(REG_TRIGGER_PERIOD, tp);
    write_reg(REG_PULSE_LENGTH, pl);
    write_reg(REG_VOLUME, vol);
  endtask

  task automatic queue_ticks(input int unsigned n, input int unsigned en_pct);
    @(negedge clk_i);
    repeat (n) tick_q.push_back($urandom_range(99) < en_pct);
  endtask

  // Wait until every tick is taken and every sample word is back, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_ch.valid || sample_exp_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  initial begin
    int unsigned         tries;
    logic [PERIOD_W-1:0] tp_r;
    logic [PERIOD_W-1:0] pl_r;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_TRIGGER_PERIOD;
    cfg_data_i   = '0;
    trig_period  = TRIG_RESET;
    pulse_len    = PULSE_RESET;
    vol_pct      = VOL_MAX;
    ph_acc       = '0;
    nxt_trig     = NEXT_RESET;
    lvl          = LVL_LOW;
    last_wp      = WP_LOW;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: low level at full volume, then silence
    queue_ticks(4, 100);
    queue_ticks(2, 0);
    wait_idle();

    // Zero periods clamp to one sample, volume all ones clamps to 100, unmapped index ignored
    write_reg(REG_UNMAPPED, PERIOD_ALL);
    write_regs('0, '0, PERIOD_ALL);
    // run up to the first trigger left from reset
    queue_ticks((NEXT_RESET >> PHASE_FRAC_BITS_DEF) + 8, 100);
    wait_idle();

    // Periods just below one sample, volume zero then one
    write_regs(SUB_SAMPLE, SUB_SAMPLE, '0);
    queue_ticks(3, 100);
    wait_idle();
    write_reg(REG_VOLUME, PERIOD_W'(1));
    queue_ticks(2, 100);
    wait_idle();

    // Stop right after a half-sample fall, then stretch the pulse: level held between ramps
    write_regs(PERIOD_W'(8 * ONE_PER), PERIOD_W'(3 * ONE_PER + (ONE_PER >> 1)),
               PERIOD_W'(VOL_MAX));
    tries = 0;
    do begin
      queue_ticks(1, 100);
      wait_idle();
      tries++;
    end while (last_wp != WP_FALL && tries < 16);
    write_reg(REG_PULSE_LENGTH, PERIOD_ALL);
    queue_ticks(4, 100);
    wait_idle();

    // Pulse longer than the period, with a fractional period
    write_regs(PERIOD_W'(2 * ONE_PER + 'h33), PERIOD_W'(7 * ONE_PER), PERIOD_W'(50));
    queue_ticks(4, 100);
    queue_ticks(1, 0);
    queue_ticks(4, 100);
    wait_idle();

    // Random settings under each idling pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 5)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 78; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 78; end
        3: begin snd_idle_pct = 8;  rcv_stall_pct = 8;  end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      tp_r = ($urandom_range(3) == 0) ? PERIOD_W'($urandom_range(SUB_SAMPLE))
                                      : PERIOD_W'($urandom_range(16 * ONE_PER, ONE_PER));
      pl_r = PERIOD_W'($urandom_range(2 * tp_r + ONE_PER));
      write_regs(tp_r, pl_r, PERIOD_W'($urandom()));
      // back-pressure phase: hold off the receiver while the sender keeps going
      hold_on = (ph % 5 == 4);
      queue_ticks(RAND_TICKS, 85);
      wait_idle();
      hold_on = 1'b0;
    end

    // Longest periods at the top of the register range
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    write_regs(PERIOD_ALL, PERIOD_ALL, PERIOD_W'(VOL_MAX));
    queue_ticks(SOAK_TICKS, 100);
    wait_idle();
    snd_idle_pct  = 8;
    rcv_stall_pct = 8;
    queue_ticks(32, 50);
    wait_idle();

    if (err_cnt == 0 && sample_exp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
